/* rtl/core/rsd_pkg.sv */
// ----------------------------------------------------------------------------
// rsd_pkg: shared types and constants for RTP stream discovery
// Table geometry, header checks, request kinds and sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none

package rsd_pkg;

  localparam int unsigned FLOW_SLOTS    = 16;
  localparam int unsigned PAYLOAD_TYPES = 128;
  localparam int unsigned SLOT_W        = $clog2(FLOW_SLOTS);
  localparam int unsigned PT_W          = $clog2(PAYLOAD_TYPES);
  localparam int unsigned HIST_AW       = SLOT_W + PT_W;
  localparam int unsigned CNT_W         = PT_W + 1;

  localparam logic [1:0]  RTP_VERSION_OK    = 2'd2;
  localparam logic [6:0]  CONFLICT_LOW      = 7'd72;
  localparam logic [6:0]  CONFLICT_HIGH     = 7'd76;
  localparam logic [3:0]  MAX_CSRC          = 4'd4;
  localparam logic [15:0] MIN_PACKETS_RESET = 16'd100;
  localparam logic [31:0] SAT32             = 32'hFFFF_FFFF;

  typedef enum logic [1:0] {
    KIND_PACKET = 2'd0,
    KIND_REPORT = 2'd1,
    KIND_CLEAR  = 2'd2,
    KIND_NONE   = 2'd3
  } kind_e;

  typedef enum logic {
    CFG_FILTER_SSRC = 1'b0,
    CFG_MIN_PACKETS = 1'b1
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_DECIDE,
    ST_HUPD,
    ST_CLEAR,
    ST_SCAN,
    ST_JUDGE,
    ST_DONE
  } state_e;

  function automatic logic [31:0] sat_inc(input logic [31:0] v);
    sat_inc = (v == SAT32) ? v : v + 32'd1;
  endfunction

endpackage

`default_nettype wire

/* rtl/core/rtp_stream_discovery.sv */
// ----------------------------------------------------------------------------
// rtp_stream_discovery: RTP flow tracker and stream classifier
// Validates RTP headers, tracks flows in a small table, judges streams.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one request: a packet
//   header, a report on one flow slot, or a table clear. Output channel
//   (out_valid_o / out_stall_i) returns exactly one result per request.
//   One request is worked at a time; in_stall_o is high while it runs.
//   Steps: a dropped packet, a clear and a report on an empty slot go
//   straight to the result; a packet of a known flow runs a 16-slot key
//   search, then a histogram read-modify-write; a packet on a full table
//   is dropped after the search; a new flow runs the search plus a
//   128-entry histogram clear; a report runs a 128-entry histogram scan
//   through the one histogram port, then the stream judgement. A new
//   request is taken only once the last one has reached its result.
//   Results sit in an output register; the next request is taken while a
//   result waits, and the block holds its finished result if the receiver
//   still stalls. Config writes (cfg_we_i) are taken any cycle.
//   Reset empties the flow table and loads filter_ssrc 0, min_packets 100.
//   The histogram memory needs no clearing pass: a slot's rows are wiped
//   whenever a flow is opened in it.
`default_nettype none

module rtp_stream_discovery (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_idx_i,
  input  wire logic [31:0] cfg_data_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [1:0]  kind_i,
  input  wire logic [31:0] src_addr_i,
  input  wire logic [15:0] src_port_i,
  input  wire logic [31:0] dst_addr_i,
  input  wire logic [15:0] dst_port_i,
  input  wire logic [31:0] ssrc_i,
  input  wire logic [15:0] seq_number_i,
  input  wire logic [31:0] media_stamp_i,
  input  wire logic [6:0]  payload_type_i,
  input  wire logic [1:0]  rtp_version_i,
  input  wire logic [3:0]  csrc_count_i,
  input  wire logic [3:0]  flow_slot_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic             accepted_o,
  output logic [3:0]       slot_index_o,
  output logic             new_flow_o,
  output logic             table_full_o,
  output logic             entry_valid_o,
  output logic             is_stream_o,
  output logic [6:0]       dominant_type_o,
  output logic [31:0]      packet_total_o
);

  localparam int unsigned NS = rsd_pkg::FLOW_SLOTS;
  localparam int unsigned SW = rsd_pkg::SLOT_W;
  localparam int unsigned PW = rsd_pkg::PT_W;
  localparam int unsigned CW = rsd_pkg::CNT_W;

  rsd_pkg::state_e state_q, state_d;

  // config
  logic [31:0] filter_ssrc_q;
  logic [15:0] min_packets_q;

  // flow table, per-slot state
  logic [NS-1:0] flow_used_q;
  logic [31:0]   key_src_addr [NS];
  logic [15:0]   key_src_port [NS];
  logic [31:0]   key_dst_addr [NS];
  logic [15:0]   key_dst_port [NS];
  logic [31:0]   key_ssrc     [NS];
  logic [31:0]   total_count  [NS];
  logic [15:0]   expected_seq [NS];
  logic [31:0]   in_seq_count [NS];
  logic [31:0]   prev_ts      [NS];
  logic [31:0]   in_ord_count [NS];

  // histogram memory
  logic [31:0]                  hist_mem [2**rsd_pkg::HIST_AW];
  logic                         hist_we;
  logic [rsd_pkg::HIST_AW-1:0]  hist_waddr, hist_raddr;
  logic [31:0]                  hist_wdata, hist_rdata_q;

  // latched request
  logic [31:0] sa_q, da_q, id_q, ts_q;
  logic [15:0] sp_q, dp_q, sn_q;
  logic [PW-1:0] pt_q;

  // sequencer
  logic [SW-1:0] idx_q, cur_q, hit_q, free_q;
  logic          hit_found_q, free_found_q;
  logic [CW-1:0] cnt_q;
  logic [31:0]   best_q;
  logic [PW-1:0] bestpt_q;

  // pending result
  logic        r_acc_q, r_new_q, r_full_q, r_ev_q, r_str_q;
  logic [3:0]  r_slot_q;
  logic [6:0]  r_dom_q;
  logic [31:0] r_tot_q;

  logic accept, hdr_ok, key_match, out_load, stream;
  logic [34:0] four_t, seq_lhs, ord_lhs;

  assign accept   = in_valid_i && (state_q == rsd_pkg::ST_IDLE);
  assign out_load = (state_q == rsd_pkg::ST_DONE) && (!out_valid_o || !out_stall_i);
  assign in_stall_o = (state_q != rsd_pkg::ST_IDLE);

  // header validity
  always_comb begin
    hdr_ok = (rtp_version_i == rsd_pkg::RTP_VERSION_OK) &&
             !(payload_type_i inside {[rsd_pkg::CONFLICT_LOW:rsd_pkg::CONFLICT_HIGH]}) &&
             (ssrc_i != 32'd0) &&
             ((filter_ssrc_q == 32'd0) || (filter_ssrc_q == ssrc_i)) &&
             (csrc_count_i <= rsd_pkg::MAX_CSRC);
  end

  assign key_match = (key_src_addr[idx_q] == sa_q) && (key_src_port[idx_q] == sp_q) &&
                     (key_dst_addr[idx_q] == da_q) && (key_dst_port[idx_q] == dp_q) &&
                     (key_ssrc[idx_q] == id_q);

  // stream judgement: cnt >= floor(4t/5) <=> 5*cnt + 5 > 4t
  always_comb begin
    four_t  = {1'b0, total_count[cur_q], 2'b00};
    seq_lhs = {1'b0, in_seq_count[cur_q], 2'b00} + {3'b000, in_seq_count[cur_q]} + 35'd5;
    ord_lhs = {1'b0, in_ord_count[cur_q], 2'b00} + {3'b000, in_ord_count[cur_q]} + 35'd5;
    stream  = (total_count[cur_q] >= {16'd0, min_packets_q}) &&
              (seq_lhs > four_t) && (ord_lhs > four_t) &&
              (best_q >= {1'b0, total_count[cur_q][31:1]});
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      rsd_pkg::ST_IDLE: begin
        if (accept) begin
          state_d = rsd_pkg::ST_DONE;
          if (kind_i == rsd_pkg::KIND_PACKET && hdr_ok) state_d = rsd_pkg::ST_SEARCH;
          if (kind_i == rsd_pkg::KIND_REPORT && flow_used_q[flow_slot_i[SW-1:0]])
            state_d = rsd_pkg::ST_SCAN;
        end
      end
      rsd_pkg::ST_SEARCH: begin
        if (idx_q == SW'(NS - 1)) state_d = rsd_pkg::ST_DECIDE;
      end
      rsd_pkg::ST_DECIDE: begin
        if (hit_found_q)       state_d = rsd_pkg::ST_HUPD;
        else if (free_found_q) state_d = rsd_pkg::ST_CLEAR;
        else                   state_d = rsd_pkg::ST_DONE;
      end
      rsd_pkg::ST_HUPD: state_d = rsd_pkg::ST_DONE;
      rsd_pkg::ST_CLEAR: begin
        if (cnt_q == CW'(rsd_pkg::PAYLOAD_TYPES - 1)) state_d = rsd_pkg::ST_DONE;
      end
      rsd_pkg::ST_SCAN: begin
        if (cnt_q == CW'(rsd_pkg::PAYLOAD_TYPES)) state_d = rsd_pkg::ST_JUDGE;
      end
      rsd_pkg::ST_JUDGE: state_d = rsd_pkg::ST_DONE;
      rsd_pkg::ST_DONE: begin
        if (out_load) state_d = rsd_pkg::ST_IDLE;
      end
      default: state_d = rsd_pkg::ST_IDLE;
    endcase
  end

  // histogram port control
  always_comb begin
    hist_we    = 1'b0;
    hist_waddr = {cur_q, pt_q};
    hist_wdata = 32'd0;
    hist_raddr = {cur_q, cnt_q[PW-1:0]};
    case (state_q)
      rsd_pkg::ST_DECIDE: hist_raddr = {hit_q, pt_q};
      rsd_pkg::ST_HUPD: begin
        hist_we    = 1'b1;
        hist_wdata = rsd_pkg::sat_inc(hist_rdata_q);
      end
      rsd_pkg::ST_CLEAR: begin
        hist_we    = 1'b1;
        hist_waddr = {cur_q, cnt_q[PW-1:0]};
        hist_wdata = {31'd0, cnt_q[PW-1:0] == pt_q};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (hist_we) hist_mem[hist_waddr] <= hist_wdata;
    hist_rdata_q <= hist_mem[hist_raddr];
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= rsd_pkg::ST_IDLE;
      filter_ssrc_q <= 32'd0;
      min_packets_q <= rsd_pkg::MIN_PACKETS_RESET;
      flow_used_q   <= '0;
      out_valid_o   <= 1'b0;
      idx_q         <= '0;
      cnt_q         <= '0;
      hit_found_q   <= 1'b0;
      free_found_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          rsd_pkg::CFG_FILTER_SSRC: filter_ssrc_q <= cfg_data_i;
          rsd_pkg::CFG_MIN_PACKETS: min_packets_q <= cfg_data_i[15:0];
          default: ;
        endcase
      end
      if (out_load)                      out_valid_o <= 1'b1;
      else if (out_valid_o && !out_stall_i) out_valid_o <= 1'b0;

      case (state_q)
        rsd_pkg::ST_IDLE: begin
          idx_q        <= '0;
          cnt_q        <= '0;
          hit_found_q  <= 1'b0;
          free_found_q <= 1'b0;
          if (accept && kind_i == rsd_pkg::KIND_CLEAR) flow_used_q <= '0;
        end
        rsd_pkg::ST_SEARCH: begin
          idx_q <= idx_q + SW'(1);
          if (flow_used_q[idx_q]) begin
            if (key_match) hit_found_q <= 1'b1;
          end else begin
            free_found_q <= 1'b1;
          end
        end
        rsd_pkg::ST_DECIDE: begin
          if (!hit_found_q && free_found_q) flow_used_q[free_q] <= 1'b1;
        end
        rsd_pkg::ST_CLEAR, rsd_pkg::ST_SCAN: cnt_q <= cnt_q + CW'(1);
        default: ;
      endcase
    end
  end

  // datapath, no reset
  always_ff @(posedge clk_i) begin
    case (state_q)
      rsd_pkg::ST_IDLE: begin
        if (accept) begin
          sa_q <= src_addr_i;  sp_q <= src_port_i;
          da_q <= dst_addr_i;  dp_q <= dst_port_i;
          id_q <= ssrc_i;      sn_q <= seq_number_i;
          ts_q <= media_stamp_i;
          pt_q <= payload_type_i;
          cur_q    <= flow_slot_i[SW-1:0];
          best_q   <= 32'd0;
          bestpt_q <= '0;
          r_acc_q <= 1'b0; r_new_q <= 1'b0; r_full_q <= 1'b0;
          r_ev_q  <= 1'b0; r_str_q <= 1'b0;
          r_slot_q <= 4'd0; r_dom_q <= 7'd0; r_tot_q <= 32'd0;
        end
      end
      rsd_pkg::ST_SEARCH: begin
        if (flow_used_q[idx_q]) begin
          if (key_match && !hit_found_q) hit_q <= idx_q;
        end else if (!free_found_q) begin
          free_q <= idx_q;
        end
      end
      rsd_pkg::ST_DECIDE: begin
        if (hit_found_q) begin
          cur_q <= hit_q;
        end else if (free_found_q) begin
          cur_q <= free_q;
          key_src_addr[free_q] <= sa_q;
          key_src_port[free_q] <= sp_q;
          key_dst_addr[free_q] <= da_q;
          key_dst_port[free_q] <= dp_q;
          key_ssrc[free_q]     <= id_q;
          total_count[free_q]  <= 32'd1;
          expected_seq[free_q] <= sn_q + 16'd1;
          in_seq_count[free_q] <= 32'd0;
          prev_ts[free_q]      <= ts_q;
          in_ord_count[free_q] <= 32'd1;
          r_acc_q  <= 1'b1;
          r_new_q  <= 1'b1;
          r_slot_q <= 4'(free_q);
        end else begin
          r_full_q <= 1'b1;
        end
      end
      rsd_pkg::ST_HUPD: begin
        total_count[cur_q] <= rsd_pkg::sat_inc(total_count[cur_q]);
        if (expected_seq[cur_q] == sn_q)
          in_seq_count[cur_q] <= rsd_pkg::sat_inc(in_seq_count[cur_q]);
        expected_seq[cur_q] <= sn_q + 16'd1;
        if (ts_q >= prev_ts[cur_q])
          in_ord_count[cur_q] <= rsd_pkg::sat_inc(in_ord_count[cur_q]);
        prev_ts[cur_q] <= ts_q;
        r_acc_q  <= 1'b1;
        r_slot_q <= 4'(cur_q);
      end
      rsd_pkg::ST_SCAN: begin
        // read data is registered and lags the address, so it belongs to entry cnt - 1
        if (cnt_q != '0 && hist_rdata_q > best_q) begin
          best_q   <= hist_rdata_q;
          bestpt_q <= PW'(cnt_q - CW'(1));
        end
      end
      rsd_pkg::ST_JUDGE: begin
        r_ev_q  <= 1'b1;
        r_str_q <= stream;
        r_dom_q <= 7'(bestpt_q);
        r_tot_q <= total_count[cur_q];
      end
      default: ;
    endcase

    if (out_load) begin
      accepted_o      <= r_acc_q;
      slot_index_o    <= r_slot_q;
      new_flow_o      <= r_new_q;
      table_full_o    <= r_full_q;
      entry_valid_o   <= r_ev_q;
      is_stream_o     <= r_str_q;
      dominant_type_o <= r_dom_q;
      packet_total_o  <= r_tot_q;
    end
  end

endmodule

`default_nettype wire
